@@ src/q2e_pkg.sv @@
// Shared constants, types and the arctangent table of the quaternion to Euler angle unit.
`default_nettype none

package q2e_pkg;

	// Output angle width and number of CORDIC rotation cells per angle
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// Datapath widths
	localparam int Q_W       = 16;  // one quaternion component, Q1.14
	localparam int PROD_W    = 32;  // product of two components
	localparam int SUM_W     = 34;  // numerators, denominators and sine of pitch, 28 fraction bits
	localparam int MAG_W     = 28;  // magnitude of an unclamped sine of pitch
	localparam int SQ_W      = 2 * MAG_W;
	localparam int RN_W      = SQ_W + 1;  // radicand, up to 2^56
	localparam int RES_W     = RN_W + 1;  // partial root with headroom for root plus bit
	localparam int ROOT_W    = MAG_W + 1; // final root, up to 2^28
	localparam int ISQ_STEPS = (RN_W + 1) / 2;
	localparam int CX_W      = 37;  // CORDIC vector, room for gain and pre-rotation
	localparam int CZ_W      = 35;  // CORDIC angle, 2^32 is a full turn
	localparam int IDX_W     = 5;   // cell index into the arctangent table

	localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

	localparam int IN_TDATA_W  = 4 * Q_W;
	localparam int OUT_TDATA_W = ((3 * ANGLE_BITS + 1 + 7) / 8) * 8;

	localparam logic signed [SUM_W-1:0] ONE_Q28    = SUM_W'(1) << 28;
	localparam logic signed [CZ_W-1:0]  HALF_PI    = CZ_W'(1) << 30;
	localparam logic signed [CZ_W-1:0]  ROUND_HALF = (CZ_W'(1) << ANGLE_SHIFT) >> 1;

	// Vector handed from one CORDIC cell to the next
	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
		logic                   zero;  // input vector was (0, 0)
	} cv_t;

	// Radicand and partial root handed from one square root cell to the next
	typedef struct packed {
		logic [RN_W-1:0]  n;
		logic [RES_W-1:0] res;
	} sq_t;

	// Terms that wait beside the square root chain
	typedef struct packed {
		logic signed [SUM_W-1:0] roll_num;
		logic signed [SUM_W-1:0] roll_den;
		logic signed [SUM_W-1:0] yaw_num;
		logic signed [SUM_W-1:0] yaw_den;
		logic signed [SUM_W-1:0] sp;
		logic                    sat_pos;
		logic                    sat_neg;
	} side_t;

	// round(atan(2^-k) * 2^32 / (2*pi))
	function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] k);
		logic [31:0] a;
		case (k)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			5'd24:   a = 32'h00000029;
			5'd25:   a = 32'h00000014;
			5'd26:   a = 32'h0000000A;
			5'd27:   a = 32'h00000005;
			5'd28:   a = 32'h00000003;
			5'd29:   a = 32'h00000001;
			5'd30:   a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ src/q2e_isqrt_cell.sv @@
// One digit step of the pipelined integer square root.
`default_nettype none

module q2e_isqrt_cell (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [q2e_pkg::IDX_W-1:0] idx,  // bit under test is 4^idx
	input  wire q2e_pkg::sq_t              d,
	output q2e_pkg::sq_t                   q
);

	logic [q2e_pkg::RES_W-1:0] bitv;
	logic [q2e_pkg::RES_W-1:0] trial;
	logic [q2e_pkg::RES_W-1:0] n_ext;
	logic [q2e_pkg::RES_W-1:0] n_left;
	q2e_pkg::sq_t              nxt;
	q2e_pkg::sq_t              q_q;

	// Try root plus bit against the remaining radicand
	always_comb begin
		bitv   = q2e_pkg::RES_W'(1) << {idx, 1'b0};
		trial  = d.res + bitv;
		n_ext  = {1'b0, d.n};
		n_left = n_ext - trial;
		if (n_ext >= trial) begin
			nxt.n   = n_left[q2e_pkg::RN_W-1:0];
			nxt.res = (d.res >> 1) + bitv;
		end else begin
			nxt.n   = d.n;
			nxt.res = d.res >> 1;
		end
	end

	// Hand the step to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end

	assign q = q_q;

endmodule

`default_nettype wire

@@ src/q2e_cordic_cell.sv @@
// One rotation of the CORDIC vectoring chain.
`default_nettype none

module q2e_cordic_cell (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [q2e_pkg::IDX_W-1:0] idx,  // shift and table entry of this cell
	input  wire q2e_pkg::cv_t              d,
	output q2e_pkg::cv_t                   q
);

	logic signed [q2e_pkg::CX_W-1:0] xi;
	logic signed [q2e_pkg::CX_W-1:0] yi;
	logic signed [q2e_pkg::CX_W-1:0] dx;
	logic signed [q2e_pkg::CX_W-1:0] dy;
	logic signed [q2e_pkg::CZ_W-1:0] ang;
	q2e_pkg::cv_t                    nxt;
	q2e_pkg::cv_t                    q_q;

	// Rotate toward the positive x axis and accumulate the angle
	always_comb begin
		xi  = d.x;
		yi  = d.y;
		dx  = yi >>> idx;
		dy  = xi >>> idx;
		ang = $signed({{(q2e_pkg::CZ_W-32){1'b0}}, q2e_pkg::atan_entry(idx)});
		nxt.zero = d.zero;
		if (yi > 0) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = d.z + ang;
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = d.z - ang;
		end
	end

	// Hand the vector to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= nxt;
		end
	end

	assign q = q_q;

endmodule

`default_nettype wire

@@ src/quaternion_to_euler_angles_unit.sv @@
// Top level: quaternion in, ZYX roll, pitch and yaw out, fully pipelined.
`default_nettype none

// Converts one unit quaternion (Q1.14) per clock into roll, pitch and yaw as binary
// angles (2^(ANGLE_BITS-1) is pi). The pipeline takes a new transaction every cycle
// and holds as a whole only when the output register is full and not taken. Its
// registers are: products, sums, square and radicand (4), one square root cell per
// result bit (29), pre-rotation (1), one CORDIC cell per rotation (CORDIC_STAGES, 16),
// and the rounding output register (1). Pitch saturates to plus or minus pi/2 and
// raises pitch_clamped when |2(wy - zx)| reaches one.
module quaternion_to_euler_angles_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [q2e_pkg::IN_TDATA_W-1:0]      s_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [q2e_pkg::OUT_TDATA_W-1:0]          m_tdata   // roll, pitch, yaw, pitch_clamped
);

	localparam int AB  = q2e_pkg::ANGLE_BITS;
	localparam int CS  = q2e_pkg::CORDIC_STAGES;
	localparam int ISQ = q2e_pkg::ISQ_STEPS;
	localparam int LAT = 4 + ISQ + 1 + CS + 1;

	localparam logic [AB-1:0] PITCH_MAX = AB'(1) << (AB - 2);
	localparam logic [AB-1:0] PITCH_MIN = ~PITCH_MAX + AB'(1);

	logic           en;
	logic [LAT-1:0] vld_q;

	// Map vector components to a CORDIC start point
	function automatic q2e_pkg::cv_t pre_rotate(input logic signed [q2e_pkg::SUM_W-1:0] yv,
			input logic signed [q2e_pkg::SUM_W-1:0] xv);
		q2e_pkg::cv_t            r;
		logic signed [q2e_pkg::CX_W-1:0] xe;
		logic signed [q2e_pkg::CX_W-1:0] ye;
		xe = {{(q2e_pkg::CX_W-q2e_pkg::SUM_W){xv[q2e_pkg::SUM_W-1]}}, xv};
		ye = {{(q2e_pkg::CX_W-q2e_pkg::SUM_W){yv[q2e_pkg::SUM_W-1]}}, yv};
		r.zero = (xv == '0) && (yv == '0);
		r.x    = xe;
		r.y    = ye;
		r.z    = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				r.x = ye;
				r.y = -xe;
				r.z = q2e_pkg::HALF_PI;
			end else begin
				r.x = -ye;
				r.y = xe;
				r.z = -q2e_pkg::HALF_PI;
			end
		end
		return r;
	endfunction

	// Round a full-turn angle to the output width
	function automatic logic [AB-1:0] round_angle(input logic signed [q2e_pkg::CZ_W-1:0] zv);
		logic signed [q2e_pkg::CZ_W-1:0] t;
		t = zv + q2e_pkg::ROUND_HALF;
		return t[q2e_pkg::ANGLE_SHIFT +: AB];
	endfunction

	// Advance the whole pipeline unless the output is full and stalled
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Stage 1: component products
	logic signed [q2e_pkg::Q_W-1:0]    qw, qx, qy, qz;
	logic signed [q2e_pkg::PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1;
	logic signed [q2e_pkg::PROD_W-1:0] wy_s1, zx_s1;

	assign qw = s_tdata[0*q2e_pkg::Q_W +: q2e_pkg::Q_W];
	assign qx = s_tdata[1*q2e_pkg::Q_W +: q2e_pkg::Q_W];
	assign qy = s_tdata[2*q2e_pkg::Q_W +: q2e_pkg::Q_W];
	assign qz = s_tdata[3*q2e_pkg::Q_W +: q2e_pkg::Q_W];

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	// Stage 2: numerators, denominators and sine of pitch
	localparam int SW = q2e_pkg::SUM_W;
	q2e_pkg::side_t          side_c;
	q2e_pkg::side_t          side_s2;
	q2e_pkg::side_t          side_s3;
	logic signed [SW-1:0]    sp_abs;
	logic [q2e_pkg::MAG_W-1:0] mag_s2;

	always_comb begin
		side_c.roll_num = (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
		side_c.roll_den = q2e_pkg::ONE_Q28 - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
		side_c.yaw_num  = (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
		side_c.yaw_den  = q2e_pkg::ONE_Q28 - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
		side_c.sp       = (SW'(wy_s1) - SW'(zx_s1)) <<< 1;
		side_c.sat_pos  = side_c.sp >= q2e_pkg::ONE_Q28;
		side_c.sat_neg  = side_c.sp <= -q2e_pkg::ONE_Q28;
		sp_abs          = (side_c.sp < 0) ? -side_c.sp : side_c.sp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c;
			mag_s2  <= sp_abs[q2e_pkg::MAG_W-1:0];
		end
	end

	// Stage 3: square of the sine
	logic [q2e_pkg::SQ_W-1:0] sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= mag_s2 * mag_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: radicand one minus sine squared
	q2e_pkg::sq_t   sqv [0:ISQ];
	q2e_pkg::side_t side_q [0:ISQ];
	q2e_pkg::sq_t   rad_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4.n   <= (q2e_pkg::RN_W'(1) << q2e_pkg::SQ_W) - q2e_pkg::RN_W'(sq_s3);
			rad_s4.res <= '0;
			side_q[0]  <= side_s3;
		end
	end

	assign sqv[0] = rad_s4;

	// Square root cells, with the other terms delayed alongside
	for (genvar i = 0; i < ISQ; i++) begin : g_isqrt
		q2e_isqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.idx (q2e_pkg::IDX_W'(ISQ - 1 - i)),
			.d   (sqv[i]),
			.q   (sqv[i+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_q[i];
			end
		end
	end

	// Stage 5: CORDIC start points
	q2e_pkg::cv_t         roll_c [0:CS];
	q2e_pkg::cv_t         yaw_c  [0:CS];
	q2e_pkg::cv_t         pit_c  [0:CS];
	logic [1:0]           sat_q  [0:CS];
	q2e_pkg::side_t       side_last;
	logic signed [SW-1:0] cos_p;

	assign side_last = side_q[ISQ];
	assign cos_p     = $signed({{(SW-q2e_pkg::ROOT_W){1'b0}},
			sqv[ISQ].res[q2e_pkg::ROOT_W-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			roll_c[0] <= pre_rotate(side_last.roll_num, side_last.roll_den);
			yaw_c[0]  <= pre_rotate(side_last.yaw_num, side_last.yaw_den);
			pit_c[0]  <= pre_rotate(side_last.sp, cos_p);
			sat_q[0]  <= {side_last.sat_neg, side_last.sat_pos};
		end
	end

	// CORDIC cells for the three angles
	for (genvar i = 0; i < CS; i++) begin : g_cordic
		q2e_cordic_cell u_roll (
			.clk (clk),
			.en  (en),
			.idx (q2e_pkg::IDX_W'(i)),
			.d   (roll_c[i]),
			.q   (roll_c[i+1])
		);

		q2e_cordic_cell u_yaw (
			.clk (clk),
			.en  (en),
			.idx (q2e_pkg::IDX_W'(i)),
			.d   (yaw_c[i]),
			.q   (yaw_c[i+1])
		);

		q2e_cordic_cell u_pitch (
			.clk (clk),
			.en  (en),
			.idx (q2e_pkg::IDX_W'(i)),
			.d   (pit_c[i]),
			.q   (pit_c[i+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sat_q[i+1] <= sat_q[i];
			end
		end
	end

	// Output stage: limit pitch, drop the roll or yaw angle of a zero vector, round
	logic signed [q2e_pkg::CZ_W-1:0] roll_z, yaw_z, pit_z;
	logic [AB-1:0]                   roll_q, pitch_q, yaw_q;
	logic                            clamp_q;

	always_comb begin
		roll_z = roll_c[CS].zero ? '0 : roll_c[CS].z;
		yaw_z  = yaw_c[CS].zero ? '0 : yaw_c[CS].z;
		pit_z  = pit_c[CS].z;
		if (pit_z > q2e_pkg::HALF_PI) begin
			pit_z = q2e_pkg::HALF_PI;
		end
		if (pit_z < -q2e_pkg::HALF_PI) begin
			pit_z = -q2e_pkg::HALF_PI;
		end
		if (sat_q[CS][0]) begin
			pit_z = q2e_pkg::HALF_PI;
		end else if (sat_q[CS][1]) begin
			pit_z = -q2e_pkg::HALF_PI;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= round_angle(roll_z);
			pitch_q <= round_angle(pit_z);
			yaw_q   <= round_angle(yaw_z);
			clamp_q <= sat_q[CS][0] || sat_q[CS][1];
		end
	end

	assign m_tdata = q2e_pkg::OUT_TDATA_W'({clamp_q, yaw_q, pitch_q, roll_q});

	// A held pipeline keeps its occupancy
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline occupancy changed while held");

	// An accepted transaction enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transaction missing from first stage");

	// Clamped pitch sits exactly at plus or minus a quarter turn
	a_clamp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && clamp_q |-> (pitch_q == PITCH_MAX) || (pitch_q == PITCH_MIN))
		else $error("clamped pitch not at plus or minus pi/2");

	// Pitch never leaves plus or minus a quarter turn
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(pitch_q) <= $signed(PITCH_MAX))
			&& ($signed(pitch_q) >= $signed(PITCH_MIN)))
		else $error("pitch outside plus or minus pi/2");

endmodule

`default_nettype wire
